### sv/chix_pkg.sv
// Package for the chained hash index engine: shared types, codes and sizes.
// Used by every module of the block; depends on nothing.
package chix_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int NODES_DEF   = 1024;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int BCNT_W      = 9;
    localparam logic [BCNT_W-1:0] BUCKET_COUNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BUCKET_COUNT = 1'd0,
        REG_BLOCK_ID     = 1'd1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key;
        logic [30:0] data_offset;
        logic [31:0] data_size;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] found_offset;
        logic [31:0] found_size;
        logic [31:0] record_count;
        logic [31:0] live_bytes;
        logic [31:0] change_version;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_NODE_RD,
        S_NODE_WAIT,
        S_NODE_CHK,
        S_ALLOC_RD,
        S_ALLOC_WAIT,
        S_COMMIT,
        S_DONE
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture the item
        logic mod_step;    // one restoring step of the bucket remainder
        logic head_rd;     // read bucket head
        logic head_take;   // cur <= head
        logic node_rd;     // read node at cur
        logic node_adv;    // prev <= cur, cur <= link
        logic alloc_rd;    // read link of free-list head
        logic commit;      // apply the change, register the result
        logic strobe;      // drive done
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic mod_last;
        logic cur_ok;
        logic key_hit;
        logic free_ok;
        logic pool_left;
        logic step_limit;
    } sts_t;

endpackage

### sv/chix_ctrl.sv
// Controller of the chained hash index engine: sequences one item at a time.
// Depends on chix_pkg.
module chix_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         operation,
    input  chix_pkg::sts_t     sts,
    output chix_pkg::cmd_t     cmd,
    output logic               busy
);

    chix_pkg::state_t state_reg, state_next;
    logic             is_ins_reg, is_ins_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chix_pkg::S_IDLE;
            is_ins_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            is_ins_reg <= is_ins_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        is_ins_next = is_ins_reg;
        cmd         = '0;
        busy        = (state_reg != chix_pkg::S_IDLE);
        unique case (state_reg)
            chix_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    is_ins_next = (operation == chix_pkg::OP_INSERT);
                    if (operation == chix_pkg::OP_NONE)
                        state_next = chix_pkg::S_COMMIT;
                    else
                        state_next = chix_pkg::S_MOD;
                end
            end
            chix_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                    state_next = chix_pkg::S_HEAD_RD;
            end
            chix_pkg::S_HEAD_RD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = chix_pkg::S_HEAD_WAIT;
            end
            chix_pkg::S_HEAD_WAIT:
            begin
                cmd.head_take = 1'b1;
                state_next    = chix_pkg::S_NODE_RD;
            end
            chix_pkg::S_NODE_RD:
            begin
                if (sts.cur_ok && !sts.step_limit)
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = chix_pkg::S_NODE_WAIT;
                end
                else if (is_ins_reg)
                    state_next = chix_pkg::S_ALLOC_RD;
                else
                    state_next = chix_pkg::S_COMMIT;
            end
            chix_pkg::S_NODE_WAIT:
                state_next = chix_pkg::S_NODE_CHK;
            chix_pkg::S_NODE_CHK:
            begin
                if (sts.key_hit)
                    state_next = chix_pkg::S_COMMIT;
                else
                begin
                    cmd.node_adv = 1'b1;
                    state_next   = chix_pkg::S_NODE_RD;
                end
            end
            chix_pkg::S_ALLOC_RD:
            begin
                cmd.alloc_rd = 1'b1;
                state_next   = chix_pkg::S_ALLOC_WAIT;
            end
            chix_pkg::S_ALLOC_WAIT:
                state_next = chix_pkg::S_COMMIT;
            chix_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = chix_pkg::S_DONE;
            end
            chix_pkg::S_DONE:
            begin
                cmd.strobe = 1'b1;
                state_next = chix_pkg::S_IDLE;
            end
            default:
                state_next = chix_pkg::S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_strobe_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.strobe |=> !busy) else $error("done not followed by idle");
    a_commit_then_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> cmd.strobe) else $error("commit not followed by done");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy) else $error("load while busy");
`endif

endmodule

### sv/chix_datapath.sv
// Datapath of the chained hash index engine: bucket remainder, memories,
// chain walk registers, counters and result register. Depends on chix_pkg.
module chix_datapath #(
    parameter int BUCKETS = chix_pkg::BUCKETS_DEF,
    parameter int NODES   = chix_pkg::NODES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  chix_pkg::in_item_t           in_item,
    input  logic                         cfg_we,
    input  logic [chix_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chix_pkg::CFG_DATA_W-1:0] cfg_data,
    input  chix_pkg::cmd_t               cmd,
    output chix_pkg::sts_t               sts,
    output chix_pkg::out_item_t          out_item
);

    localparam int LW   = $clog2(NODES + 1);
    localparam int NAW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int BAW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW   = $clog2(BUCKETS + 1);
    localparam int SW   = $clog2(NODES + 2);
    localparam logic [LW-1:0] NODES_L = LW'(NODES);

    // Configuration.
    logic [chix_pkg::BCNT_W-1:0] bcount_reg;
    logic [31:0]                 block_id_reg;

    // Item and walk registers.
    chix_pkg::in_item_t item_reg;
    logic [DW-1:0]      div_reg;
    logic [DW:0]        rem_reg;
    logic [5:0]         bit_reg;
    logic [LW-1:0]      cur_reg, prev_reg;
    logic [SW-1:0]      steps_reg;

    // Persistent state.
    logic [LW-1:0]      free_head_reg, next_unused_reg;
    logic [31:0]        live_count_reg, live_size_reg, version_reg;
    logic [BUCKETS-1:0] head_valid_reg;

    // Result registers.
    logic [1:0]  res_status_reg, res_status_next;
    logic [30:0] res_off_reg, res_off_next;
    logic [31:0] res_size_reg, res_size_next;

    // Memories.
    logic [LW-1:0] head_mem [BUCKETS];
    logic [63:0]   key_mem  [NODES];
    logic [30:0]   off_mem  [NODES];
    logic [31:0]   size_mem [NODES];
    logic [LW-1:0] link_mem [NODES];
    logic [LW-1:0] head_rd_reg;
    logic          head_vld_rd_reg;
    logic [63:0]   key_rd_reg;
    logic [30:0]   off_rd_reg;
    logic [31:0]   size_rd_reg;
    logic [LW-1:0] link_rd_reg;

    logic [BAW-1:0] slot;
    logic [DW-1:0]  div_eff;
    logic [DW:0]    rem_sh;
    logic           cur_ok, free_ok;
    logic [NAW-1:0] cur_a, prev_a, free_a, new_a, node_a;
    logic [LW-1:0]  new_link;
    logic           hit;

    // Pending second link write.
    logic           pend_reg;
    logic [NAW-1:0] pend_a_reg;
    logic [LW-1:0]  pend_d_reg;

    function automatic logic out_ok_ins();
        out_ok_ins = !cur_ok && (free_ok || next_unused_reg < NODES_L);
    endfunction

    always_comb
    begin
        if (bcount_reg == '0)
            div_eff = DW'(1);
        else if ({{(32-chix_pkg::BCNT_W){1'b0}}, bcount_reg} > 32'(BUCKETS))
            div_eff = DW'(BUCKETS);
        else
            div_eff = DW'(bcount_reg);
    end

    assign rem_sh  = {rem_reg[DW-1:0], item_reg.key[bit_reg[4:0]]};
    assign slot    = BAW'(rem_reg);
    assign cur_ok  = (cur_reg != '0) && (cur_reg <= NODES_L);
    assign free_ok = (free_head_reg != '0) && (free_head_reg <= NODES_L);
    assign cur_a   = NAW'(cur_reg - LW'(1));
    assign prev_a  = NAW'(prev_reg - LW'(1));
    assign free_a  = NAW'(free_head_reg - LW'(1));
    assign new_a   = free_ok ? free_a : NAW'(next_unused_reg);
    assign new_link = free_ok ? free_head_reg : next_unused_reg + LW'(1);
    assign hit     = (key_rd_reg == item_reg.key);
    assign node_a  = cmd.alloc_rd ? free_a : cur_a;

    assign sts.mod_last   = (bit_reg == 6'd0);
    assign sts.cur_ok     = cur_ok;
    assign sts.key_hit    = hit;
    assign sts.free_ok    = free_ok;
    assign sts.pool_left  = (next_unused_reg < NODES_L);
    assign sts.step_limit = (steps_reg >= SW'(NODES));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg   <= chix_pkg::BUCKET_COUNT_RESET;
            block_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chix_pkg::REG_BUCKET_COUNT: bcount_reg <= cfg_data[chix_pkg::BCNT_W-1:0];
                chix_pkg::REG_BLOCK_ID:     block_id_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item capture, bit-serial remainder and chain walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            div_reg  <= div_eff;
            rem_reg  <= '0;
            bit_reg  <= 6'd31;
        end
        if (cmd.mod_step)
        begin
            if (rem_sh >= {1'b0, div_reg})
                rem_reg <= rem_sh - {1'b0, div_reg};
            else
                rem_reg <= rem_sh;
            bit_reg <= bit_reg - 6'd1;
        end
        if (cmd.head_take)
        begin
            cur_reg   <= head_vld_rd_reg ? head_rd_reg : '0;
            prev_reg  <= '0;
            steps_reg <= '0;
        end
        if (cmd.node_adv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_rd_reg;
            steps_reg <= steps_reg + SW'(1);
        end
    end

    // Bucket head memory; the valid bits stand in for the cleared reset value.
    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
        begin
            head_rd_reg <= head_mem[slot];
        end
        if (cmd.commit && item_reg.operation != chix_pkg::OP_NONE && prev_reg == '0)
        begin
            if ((item_reg.operation == chix_pkg::OP_INSERT && out_ok_ins())
                || (item_reg.operation == chix_pkg::OP_DELETE && cur_ok))
                head_mem[slot] <= (item_reg.operation == chix_pkg::OP_INSERT)
                                  ? new_link : link_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= '0;
            head_vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.head_rd)
                head_vld_rd_reg <= head_valid_reg[slot];
            if (cmd.commit && prev_reg == '0
                && ((item_reg.operation == chix_pkg::OP_INSERT && out_ok_ins())
                    || (item_reg.operation == chix_pkg::OP_DELETE && cur_ok)))
                head_valid_reg[slot] <= 1'b1;
        end
    end

    // Node memories: one read port, one write port.
    always_ff @(posedge clk)
    begin
        if (cmd.node_rd || cmd.alloc_rd)
        begin
            key_rd_reg  <= key_mem[node_a];
            off_rd_reg  <= off_mem[node_a];
            size_rd_reg <= size_mem[node_a];
            link_rd_reg <= link_mem[node_a];
        end
        if (cmd.commit && item_reg.operation == chix_pkg::OP_INSERT && out_ok_ins())
        begin
            key_mem[new_a]  <= item_reg.key;
            off_mem[new_a]  <= item_reg.data_offset;
            size_mem[new_a] <= item_reg.data_size;
        end
    end

    // Link memory writes: insert writes the new node and maybe the tail,
    // delete writes the freed node and maybe the predecessor. A write to the
    // tail or predecessor goes in the cycle after commit from a pending slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= cmd.commit && prev_reg != '0
                && ((item_reg.operation == chix_pkg::OP_INSERT && out_ok_ins())
                    || (item_reg.operation == chix_pkg::OP_DELETE && cur_ok));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pend_a_reg <= prev_a;
            pend_d_reg <= (item_reg.operation == chix_pkg::OP_INSERT)
                          ? new_link : link_rd_reg;
        end
        if (pend_reg)
            link_mem[pend_a_reg] <= pend_d_reg;
        else if (cmd.commit && item_reg.operation == chix_pkg::OP_INSERT && out_ok_ins())
            link_mem[new_a] <= '0;
        else if (cmd.commit && item_reg.operation == chix_pkg::OP_DELETE && cur_ok)
            link_mem[cur_a] <= free_head_reg;
    end

    // Free list, counters and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg   <= '0;
            next_unused_reg <= '0;
            live_count_reg  <= '0;
            live_size_reg   <= '0;
            version_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            if (item_reg.operation == chix_pkg::OP_INSERT && out_ok_ins())
            begin
                if (free_ok)
                    free_head_reg <= link_rd_reg;
                else
                    next_unused_reg <= next_unused_reg + LW'(1);
                if (block_id_reg != '0)
                begin
                    version_reg    <= version_reg + 32'd1;
                    live_count_reg <= live_count_reg + 32'd1;
                    live_size_reg  <= live_size_reg + item_reg.data_size;
                end
            end
            else if (item_reg.operation == chix_pkg::OP_DELETE && cur_ok)
            begin
                free_head_reg <= cur_reg;
                if (block_id_reg != '0)
                begin
                    version_reg    <= version_reg + 32'd1;
                    live_count_reg <= live_count_reg - 32'd1;
                    live_size_reg  <= live_size_reg - size_rd_reg;
                end
            end
        end
    end

    always_comb
    begin
        out_item.record_count   = live_count_reg;
        out_item.live_bytes     = live_size_reg;
        out_item.change_version = version_reg;
        out_item.status         = res_status_reg;
        out_item.found_offset   = res_off_reg;
        out_item.found_size     = res_size_reg;
    end

    always_comb
    begin
        res_status_next = chix_pkg::ST_OK;
        res_off_next    = '0;
        res_size_next   = '0;
        unique case (item_reg.operation)
            chix_pkg::OP_INSERT:
                if (cur_ok)
                    res_status_next = chix_pkg::ST_PRESENT;
                else if (!out_ok_ins())
                    res_status_next = chix_pkg::ST_FULL;
            chix_pkg::OP_LOOKUP:
                if (cur_ok)
                begin
                    res_off_next  = off_rd_reg;
                    res_size_next = size_rd_reg;
                end
                else
                    res_status_next = chix_pkg::ST_MISSING;
            chix_pkg::OP_DELETE:
                if (!cur_ok)
                    res_status_next = chix_pkg::ST_MISSING;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_status_reg <= res_status_next;
            res_off_reg    <= res_off_next;
            res_size_reg   <= res_size_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_unused_reg <= NODES_L) else $error("pool index past end");
    a_free_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= NODES_L) else $error("free head out of range");
    a_pend_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.commit)) else $error("stray link write");
`endif

endmodule

### sv/chained_hash_index_engine.sv
// Top level of the chained hash index engine.
// Joins chix_ctrl and chix_datapath; depends on chix_pkg.
//
// Usage: pulse start with an item (operation, key, data offset and size)
// while busy is low. The block raises busy on the next cycle and, when the
// item is finished, shows one result on the result port with done high for
// exactly one cycle; the receiver cannot hold it off.
// Configuration: write bucket_count (index 0) or block_id (index 1) through
// cfg_we/cfg_index/cfg_data while busy is low; a write takes effect at once.
// Steps: bit-serial remainder of the low key half by the bucket count, a read
// of the bucket head, a read and check of each chain node examined (one
// registered node-memory read port), a last check when the walk runs off the
// chain end, a read of the free list on an insert that misses, then commit and
// done; an unknown operation goes from the accept straight to commit and done.
// A new item is taken the cycle after done. Reset clears the chains (per-bucket
// valid bits), the free list, the pool index and all counters; node memories
// are left as they are and are only read after being written.
module chained_hash_index_engine #(
    parameter int BUCKETS = chix_pkg::BUCKETS_DEF,
    parameter int NODES   = chix_pkg::NODES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  chix_pkg::in_item_t              item,
    output logic                            done,
    output chix_pkg::out_item_t             result,
    input  logic                            cfg_we,
    input  logic [chix_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chix_pkg::CFG_DATA_W-1:0] cfg_data
);

    chix_pkg::cmd_t cmd;
    chix_pkg::sts_t sts;

    chix_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    chix_datapath #(
        .BUCKETS (BUCKETS),
        .NODES   (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (result)
    );

    // The result register is loaded at commit and shown in the next cycle.
    assign done = cmd.strobe;

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
`endif

endmodule
